[sv/rcr_pkg.sv]
// Shared types and constants for the random click resonator.
`default_nettype none

package rcr_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RLD,
		ST_SMP,
		ST_KSIN,
		ST_DIFF,
		ST_DEC,
		ST_UPD
	} rcr_state_t;

	// register index, taken from paddr[2]
	localparam logic REG_MAX_INTERVAL = 1'b0;
	localparam logic REG_DECAY_GAIN   = 1'b1;

	localparam int          MAX_INTERVAL_RST = 88200;
	localparam logic [15:0] DECAY_GAIN_RST   = 16'd64880;
	localparam int          FULL_SCALE       = 32767;
	localparam int          GAIN_BITS        = 16;

endpackage

`default_nettype wire

[sv/random_click_resonator.sv]
// Random click generator with a damped magic-circle resonator, one shared multiplier.
//
//  channel   | dir | handshake                  | payload
//  ----------+-----+----------------------------+----------------------------------------
//  s_axis    | in  | s_axis_tvalid/tready       | tdata[15:0] random_value
//  m_axis    | out | m_axis_tvalid/tready       | tdata[15:0] sample, tuser[0] click_start
//  apb       | in  | psel/penable/pwrite/pready | 0x0 max_interval, 0x4 decay_gain
//
// After an input transfer the sequencer steps through SMP, KSIN, DIFF, DEC and UPD, with
// RLD first when it starts a click (one extra multiply for the reload); every multiply goes
// through the single multiplier. No new input is taken until UPD fires; then the result
// becomes valid and s_axis_tready returns in the same cycle.
// The last step stalls while the output register is full and its transfer is not taken.
// arst_n clears the state to countdown 0, cosine 1.0, sine 0 and the register resets.
`default_nettype none

module random_click_resonator
	import rcr_pkg::*;
#(
	parameter int INTERVAL_BITS = 24,
	parameter int FRACTION_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,   // [15:0] random_value
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [15:0] m_axis_tdata,   // [15:0] sample
	output logic      [0:0]  m_axis_tuser    // [0] click_start
);

	localparam int TERM_BITS = FRACTION_BITS + 8;
	localparam int AW = TERM_BITS + 1;
	localparam int BMAX0 = (INTERVAL_BITS > 16) ? INTERVAL_BITS : 16;
	localparam int BW = ((BMAX0 > FRACTION_BITS) ? BMAX0 : FRACTION_BITS) + 1;
	localparam int PW = AW + BW;
	localparam int CW = INTERVAL_BITS + 1;
	localparam int K_POINT3 = ((3 << FRACTION_BITS) + 5) / 10;

	localparam logic signed [PW-1:0] SMP_MAX  = PW'(FULL_SCALE);
	localparam logic signed [PW-1:0] SMP_MIN  = -SMP_MAX - PW'(1);
	localparam logic signed [PW-1:0] TERM_MAX = (PW'(1) <<< (TERM_BITS - 1)) - PW'(1);
	localparam logic signed [PW-1:0] TERM_MIN = -TERM_MAX - PW'(1);
	localparam logic signed [TERM_BITS-1:0] ONE_Q = TERM_BITS'(1) << FRACTION_BITS;

	rcr_state_t state_q, state_d;

	logic [INTERVAL_BITS-1:0]    max_interval_q;
	logic [15:0]                 decay_gain_q;
	logic signed [CW-1:0]        countdown_q;
	logic signed [TERM_BITS-1:0] cos_q, sin_q;
	logic [15:0]                 rnd_q;
	logic                        start_q;
	logic signed [AW-1:0]        diff_q;
	logic signed [PW-1:0]        prod_q;
	logic [15:0]                 smp_q;
	logic                        out_valid_q;
	logic [15:0]                 out_sample_q;
	logic                        out_start_q;

	logic signed [AW-1:0]        op_a;
	logic signed [BW-1:0]        op_b;
	logic signed [PW-1:0]        prod_d;
	logic signed [PW-1:0]        smp_trunc, ksin_floor, nc_full;
	logic [15:0]                 smp_sat;
	logic signed [TERM_BITS-1:0] nc_sat, ns_sat;
	logic signed [AW-1:0]        ns_full;
	logic                        in_xfer, out_xfer, cfg_wr, upd_fire;

	assign pready        = 1'b1;
	assign cfg_wr        = psel && penable && pwrite && pready;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign out_xfer      = m_axis_tvalid && m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_sample_q;
	assign m_axis_tuser  = out_start_q;

	always_comb begin
		case (paddr[2])
			REG_MAX_INTERVAL: prdata = 32'(max_interval_q);
			REG_DECAY_GAIN:   prdata = 32'(decay_gain_q);
			default:          prdata = '0;
		endcase
	end

	// shared multiplier operand select
	always_comb begin
		case (state_q)
			ST_RLD: begin
				op_a = AW'(rnd_q);
				op_b = BW'(max_interval_q);
			end
			ST_SMP: begin
				op_a = AW'(cos_q);
				op_b = BW'(FULL_SCALE);
			end
			ST_KSIN: begin
				op_a = AW'(sin_q);
				op_b = BW'(K_POINT3);
			end
			ST_DEC: begin
				op_a = diff_q;
				op_b = BW'(decay_gain_q);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign prod_d = PW'(op_a) * PW'(op_b);

	// cos*32767 >> FRACTION_BITS toward zero, then saturate
	always_comb begin
		smp_trunc = (prod_q >>> FRACTION_BITS)
			+ $signed(PW'(prod_q[PW-1] && (prod_q[FRACTION_BITS-1:0] != '0)));
		if (smp_trunc > SMP_MAX)
			smp_sat = 16'(SMP_MAX);
		else if (smp_trunc < SMP_MIN)
			smp_sat = 16'(SMP_MIN);
		else
			smp_sat = 16'(smp_trunc);
	end

	assign ksin_floor = prod_q >>> FRACTION_BITS;
	assign nc_full    = prod_q >>> GAIN_BITS;

	always_comb begin
		if (nc_full > TERM_MAX)
			nc_sat = TERM_BITS'(TERM_MAX);
		else if (nc_full < TERM_MIN)
			nc_sat = TERM_BITS'(TERM_MIN);
		else
			nc_sat = TERM_BITS'(nc_full);
		ns_full = AW'(sin_q) + AW'(nc_sat);
		if (ns_full[AW-1] != ns_full[AW-2])
			ns_sat = ns_full[AW-1] ? TERM_BITS'(TERM_MIN) : TERM_BITS'(TERM_MAX);
		else
			ns_sat = ns_full[TERM_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		upd_fire      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid)
					state_d = countdown_q[CW-1] ? ST_RLD : ST_SMP;
			end
			ST_RLD:  state_d = ST_SMP;
			ST_SMP:  state_d = ST_KSIN;
			ST_KSIN: state_d = ST_DIFF;
			ST_DIFF: state_d = ST_DEC;
			ST_DEC:  state_d = ST_UPD;
			ST_UPD: begin
				if (!out_valid_q || m_axis_tready) begin
					upd_fire = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		// decay product is held while the update waits on the output
		if (state_q != ST_UPD)
			prod_q <= prod_d;
		if (in_xfer)
			rnd_q <= s_axis_tdata;
		if (state_q == ST_KSIN)
			smp_q <= smp_sat;
		if (state_q == ST_DIFF)
			diff_q <= AW'(cos_q) - AW'(ksin_floor);
		if (upd_fire) begin
			out_sample_q <= smp_q;
			out_start_q  <= start_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_interval_q <= INTERVAL_BITS'(MAX_INTERVAL_RST);
			decay_gain_q   <= DECAY_GAIN_RST;
			countdown_q    <= '0;
			cos_q          <= ONE_Q;
			sin_q          <= '0;
			start_q        <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_wr) begin
				case (paddr[2])
					REG_MAX_INTERVAL: max_interval_q <= pwdata[INTERVAL_BITS-1:0];
					REG_DECAY_GAIN:   decay_gain_q   <= pwdata[15:0];
					default: ;
				endcase
			end
			if (in_xfer) begin
				start_q <= countdown_q[CW-1];
				if (countdown_q[CW-1]) begin
					cos_q <= ONE_Q;
					sin_q <= '0;
				end else begin
					countdown_q <= countdown_q - CW'(1);
				end
			end
			// reload product lands while the sample multiply is issued
			if (state_q == ST_SMP && start_q)
				countdown_q <= CW'(prod_q[INTERVAL_BITS+15:16]);
			if (upd_fire) begin
				cos_q <= nc_sat;
				sin_q <= ns_sat;
			end
			if (upd_fire)
				out_valid_q <= 1'b1;
			else if (out_xfer)
				out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

[sv/rcr_checker.sv]
// Port-level assertions for the random click resonator, bound to the top level.
`default_nettype none

module rcr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        pready,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [15:0] m_axis_tdata,
	input wire logic [0:0]  m_axis_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=>
			!s_axis_tready ##1 !s_axis_tready ##1 !s_axis_tready ##1 !s_axis_tready)
		else $error("input taken during sample sequence");

	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result appeared without a sample in flight");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready dropped");

endmodule

bind random_click_resonator rcr_checker u_rcr_checker (.*);

`default_nettype wire
